// File: rtl/bsp_pkg.sv
// Shared types and constants for the Bezier surface point evaluator.
package bsp_pkg;

  localparam int MAX_ROWS = 8;
  localparam int MAX_COLS = 8;
  localparam int WORK_D   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CNT_W    = $clog2(WORK_D + 1);
  localparam int ST_AW    = $clog2(MAX_ROWS * MAX_COLS);
  localparam int WK_AW    = $clog2(2 * WORK_D);
  localparam int SBASE    = WORK_D;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic       REQ_WRITE = 1'b0;
  localparam logic       REQ_EVAL  = 1'b1;
  localparam logic       CFG_ROWS  = 1'b0;
  localparam logic       CFG_COLS  = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic             we;
    logic [ST_AW-1:0] addr;
    point_t           data;
  } st_wr_t;

  typedef struct packed {
    logic             we;
    logic [WK_AW-1:0] addr;
    point_t           data;
  } wk_wr_t;

endpackage

// File: rtl/bsp_if.sv
// Valid/ready channel interfaces for request and result words.
interface bsp_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [2:0]         row_index;
  logic [2:0]         col_index;
  logic signed [31:0] ctrl_x;
  logic signed [31:0] ctrl_y;
  logic signed [31:0] ctrl_z;
  logic [16:0]        param_u;
  logic [16:0]        param_v;
  modport source (output valid, req_type, row_index, col_index, ctrl_x, ctrl_y, ctrl_z,
                  param_u, param_v, input ready);
  modport sink (input valid, req_type, row_index, col_index, ctrl_x, ctrl_y, ctrl_z,
                param_u, param_v, output ready);
endinterface

interface bsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: rtl/bsp_store.sv
// Control point memory, one write port and one registered read port.
module bsp_store (
  input  logic                    clk,
  input  bsp_pkg::st_wr_t         wr,
  input  logic [bsp_pkg::ST_AW-1:0] rd_addr,
  output bsp_pkg::point_t         rd_data
);
  bsp_pkg::point_t mem [bsp_pkg::MAX_ROWS*bsp_pkg::MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/bsp_work.sv
// Work memory: column triangle entries in the low half, per-column results above.
module bsp_work (
  input  logic                      clk,
  input  bsp_pkg::wk_wr_t           wr,
  input  logic [bsp_pkg::WK_AW-1:0] rd_addr,
  output bsp_pkg::point_t           rd_data
);
  bsp_pkg::point_t mem [2*bsp_pkg::WORK_D];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// File: rtl/bsp_lerp.sv
// Three-coordinate linear step a + round(t*(b-a)), ties rounded upward.
module bsp_lerp (
  input  bsp_pkg::point_t a,
  input  bsp_pkg::point_t b,
  input  logic [16:0]     t,
  output bsp_pkg::point_t y
);
  function automatic logic signed [31:0] lerp1(input logic signed [31:0] pa,
                                               input logic signed [31:0] pb,
                                               input logic [16:0] pt);
    logic signed [32:0] diff;
    logic signed [17:0] ts;
    logic signed [50:0] prod;
    logic signed [50:0] q;
    diff = 33'(pb) - 33'(pa);
    ts   = {1'b0, pt};
    prod = 51'(diff) * 51'(ts);
    q    = prod + 51'sd32768;
    return pa + q[47:16];
  endfunction

  assign y.x = lerp1(a.x, b.x, t);
  assign y.y = lerp1(a.y, b.y, t);
  assign y.z = lerp1(a.z, b.z, t);
endmodule

// File: rtl/bezier_surface_point_eval.sv
// Top level: Bezier surface point evaluation by de Casteljau reduction in memory.
// A write word leaves the block idle, so it stays ready for the next word. An evaluate
// word keeps the block busy through the column and row reductions, and waits while the
// previous result word is unaccepted; the block takes the next word from the cycle in
// which the result word is valid. The single read port of the work memory, one read each
// cycle, paces the reduction. Reset (synchronous, rst_n low) restores the 4x4 grid.
module bezier_surface_point_eval (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  bsp_in_if.sink      in_,
  bsp_out_if.source   out_
);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_LVL  = 6'b000100,
    ST_GAP  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam int CW = bsp_pkg::CNT_W;
  localparam int WA = bsp_pkg::WK_AW;
  localparam int SA = bsp_pkg::ST_AW;

  state_t state_r, state_nxt;

  logic [3:0]    rows_cfg_r, cols_cfg_r;
  logic [CW-1:0] rows, cols;
  logic [16:0]   u_r, v_r, u_nxt, v_nxt;
  logic          phase_r, phase_nxt;      // 0: reducing columns, 1: reducing the row
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] rcnt_r, rcnt_nxt;
  logic [CW-1:0] len_r, len_nxt;

  // Read-return tracking: memory read data is registered and arrives in the cycle after the read.
  logic          ld_vld_r, lv_vld_r, lv_last_r;
  logic [CW-1:0] rd_idx_r;
  bsp_pkg::point_t prev_r;

  bsp_pkg::st_wr_t st_wr;
  bsp_pkg::wk_wr_t wk_wr;
  logic [SA-1:0]   st_raddr;
  logic [WA-1:0]   wk_raddr;
  bsp_pkg::point_t st_rdata, wk_rdata, lerp_y;

  logic               out_valid_r;
  bsp_pkg::point_t    out_r;

  logic in_acc, out_free;

  // Clamp the configured grid size to 1..MAX.
  always_comb begin
    if (rows_cfg_r == 4'd0) begin
      rows = CW'(1);
    end else if (32'(rows_cfg_r) > bsp_pkg::MAX_ROWS) begin
      rows = CW'(bsp_pkg::MAX_ROWS);
    end else begin
      rows = CW'(rows_cfg_r);
    end
    if (cols_cfg_r == 4'd0) begin
      cols = CW'(1);
    end else if (32'(cols_cfg_r) > bsp_pkg::MAX_COLS) begin
      cols = CW'(bsp_pkg::MAX_COLS);
    end else begin
      cols = CW'(cols_cfg_r);
    end
  end

  assign in_.ready = (state_r == ST_IDLE);
  assign in_acc    = in_.valid && in_.ready;
  assign out_free  = !out_valid_r || out_.ready;

  // Control point writes come straight from the request word.
  always_comb begin
    st_wr.we     = in_acc && (in_.req_type == bsp_pkg::REQ_WRITE) &&
                   (32'(in_.row_index) < bsp_pkg::MAX_ROWS) &&
                   (32'(in_.col_index) < bsp_pkg::MAX_COLS);
    st_wr.addr   = SA'(32'(in_.row_index) * bsp_pkg::MAX_COLS + 32'(in_.col_index));
    st_wr.data.x = in_.ctrl_x;
    st_wr.data.y = in_.ctrl_y;
    st_wr.data.z = in_.ctrl_z;
  end

  assign st_raddr = SA'(32'(rcnt_r) * bsp_pkg::MAX_COLS + 32'(col_r));

  always_comb begin
    if (state_r == ST_FIN) begin
      wk_raddr = WA'(bsp_pkg::SBASE);
    end else if (phase_r) begin
      wk_raddr = WA'(bsp_pkg::SBASE) + WA'(rcnt_r);
    end else begin
      wk_raddr = WA'(rcnt_r);
    end
  end

  bsp_lerp u_lerp (
    .a (prev_r),
    .b (wk_rdata),
    .t (phase_r ? v_r : u_r),
    .y (lerp_y)
  );

  // Work memory writes: loaded control points, or lerp results of a level. The last
  // level of a column lands directly in that column's scratch entry.
  always_comb begin
    wk_wr = '0;
    if (ld_vld_r) begin
      wk_wr.we   = 1'b1;
      wk_wr.data = st_rdata;
      wk_wr.addr = (rows == CW'(1)) ? WA'(bsp_pkg::SBASE) + WA'(col_r) : WA'(rd_idx_r);
    end else if (lv_vld_r && (rd_idx_r != '0)) begin
      wk_wr.we   = 1'b1;
      wk_wr.data = lerp_y;
      if (phase_r) begin
        wk_wr.addr = WA'(bsp_pkg::SBASE) + WA'(rd_idx_r - CW'(1));
      end else if (lv_last_r) begin
        wk_wr.addr = WA'(bsp_pkg::SBASE) + WA'(col_r);
      end else begin
        wk_wr.addr = WA'(rd_idx_r - CW'(1));
      end
    end
  end

  bsp_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  bsp_work u_work (
    .clk     (clk),
    .wr      (wk_wr),
    .rd_addr (wk_raddr),
    .rd_data (wk_rdata)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    phase_nxt = phase_r;
    col_nxt   = col_r;
    rcnt_nxt  = rcnt_r;
    len_nxt   = len_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_.req_type == bsp_pkg::REQ_EVAL)) begin
          u_nxt     = (in_.param_u > bsp_pkg::ONE_Q16) ? bsp_pkg::ONE_Q16 : in_.param_u;
          v_nxt     = (in_.param_v > bsp_pkg::ONE_Q16) ? bsp_pkg::ONE_Q16 : in_.param_v;
          phase_nxt = 1'b0;
          col_nxt   = '0;
          rcnt_nxt  = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rcnt_nxt = rcnt_r + CW'(1);
        if (rcnt_r == rows - CW'(1)) begin
          len_nxt   = rows;
          state_nxt = ST_GAP;
        end
      end
      ST_LVL: begin
        rcnt_nxt = rcnt_r + CW'(1);
        if (rcnt_r == len_r - CW'(1)) begin
          len_nxt   = len_r - CW'(1);
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        rcnt_nxt = '0;
        if (len_r >= CW'(2)) begin
          state_nxt = ST_LVL;
        end else if (phase_r) begin
          state_nxt = ST_FIN;
        end else if (col_r == cols - CW'(1)) begin
          phase_nxt = 1'b1;
          len_nxt   = cols;
        end else begin
          col_nxt   = col_r + CW'(1);
          state_nxt = ST_LOAD;
        end
      end
      ST_FIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = out_free ? ST_IDLE : ST_FIN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_cfg_r  <= 4'd4;
      cols_cfg_r  <= 4'd4;
      ld_vld_r    <= 1'b0;
      lv_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ld_vld_r <= (state_r == ST_LOAD);
      lv_vld_r <= (state_r == ST_LVL);
      if (cfg_we) begin
        if (cfg_index == bsp_pkg::CFG_ROWS) begin
          rows_cfg_r <= cfg_wdata;
        end else begin
          cols_cfg_r <= cfg_wdata;
        end
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    col_r     <= col_nxt;
    rcnt_r    <= rcnt_nxt;
    len_r     <= len_nxt;
    rd_idx_r  <= rcnt_r;
    lv_last_r <= (len_r == CW'(2));
    if (lv_vld_r) begin
      prev_r <= wk_rdata;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_r <= wk_rdata;
    end
  end

  assign out_.valid   = out_valid_r;
  assign out_.point_x = out_r.x;
  assign out_.point_y = out_r.y;
  assign out_.point_z = out_r.z;

endmodule

// File: tb/tb_bsp_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard class that predicts Bezier surface points and checks result words.
class bsp_scoreboard;
  logic signed [31:0] ctrl_pts [0:bsp_pkg::MAX_ROWS*bsp_pkg::MAX_COLS-1][0:2];
  int unsigned        rows_reg;
  int unsigned        cols_reg;
  bsp_pkg::point_t    pending_points [$];
  int                 mismatch_count;

  function new();
    rows_reg = 4;
    cols_reg = 4;
    mismatch_count = 0;
    for (int i = 0; i < bsp_pkg::MAX_ROWS*bsp_pkg::MAX_COLS; i++) begin
      for (int k = 0; k < 3; k++) ctrl_pts[i][k] = '0;
    end
  endfunction

  function void set_reg(logic idx, logic [3:0] val);
    if (idx == bsp_pkg::CFG_ROWS) rows_reg = val;
    else cols_reg = val;
  endfunction

  // Linear step a + round(t*(b-a)/65536), ties upward; floor shift does it.
  function longint blend(longint a, longint b, longint t);
    longint p;
    p = t * (b - a) + 32768;
    return a + (p >>> 16);
  endfunction

  function void note_input(logic req, logic [2:0] r, logic [2:0] c,
                           logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic [16:0] pu, logic [16:0] pv);
    int unsigned nr, nc;
    longint u, v;
    longint col_pt [0:bsp_pkg::MAX_ROWS-1][0:2];
    longint row_pt [0:bsp_pkg::MAX_COLS-1][0:2];
    bsp_pkg::point_t res;
    if (req == bsp_pkg::REQ_WRITE) begin
      ctrl_pts[r*bsp_pkg::MAX_COLS + c][0] = x;
      ctrl_pts[r*bsp_pkg::MAX_COLS + c][1] = y;
      ctrl_pts[r*bsp_pkg::MAX_COLS + c][2] = z;
      return;
    end
    nr = (rows_reg == 0) ? 1 : (rows_reg > bsp_pkg::MAX_ROWS) ? bsp_pkg::MAX_ROWS : rows_reg;
    nc = (cols_reg == 0) ? 1 : (cols_reg > bsp_pkg::MAX_COLS) ? bsp_pkg::MAX_COLS : cols_reg;
    u = (pu > bsp_pkg::ONE_Q16) ? 65536 : pu;
    v = (pv > bsp_pkg::ONE_Q16) ? 65536 : pv;
    for (int j = 0; j < nc; j++) begin
      for (int i = 0; i < nr; i++)
        for (int k = 0; k < 3; k++) col_pt[i][k] = ctrl_pts[i*bsp_pkg::MAX_COLS + j][k];
      for (int l = 1; l < nr; l++)
        for (int i = 0; i + l < nr; i++)
          for (int k = 0; k < 3; k++) col_pt[i][k] = blend(col_pt[i][k], col_pt[i+1][k], u);
      for (int k = 0; k < 3; k++) row_pt[j][k] = col_pt[0][k];
    end
    for (int l = 1; l < nc; l++)
      for (int j = 0; j + l < nc; j++)
        for (int k = 0; k < 3; k++) row_pt[j][k] = blend(row_pt[j][k], row_pt[j+1][k], v);
    res.x = row_pt[0][0][31:0];
    res.y = row_pt[0][1][31:0];
    res.z = row_pt[0][2][31:0];
    pending_points.push_back(res);
  endfunction

  task report(string what, logic signed [31:0] got, logic signed [31:0] exp_v);
    mismatch_count++;
    $display("MISMATCH %s: got %0d expected %0d", what, got, exp_v);
  endtask

  task check_result(logic signed [31:0] x, logic signed [31:0] y,
                    logic signed [31:0] z);
    bsp_pkg::point_t e;
    if (pending_points.size() == 0) begin
      report("unexpected word", x, 0);
      return;
    end
    e = pending_points.pop_front();
    if (x !== e.x) report("point_x", x, e.x);
    if (y !== e.y) report("point_y", y, e.y);
    if (z !== e.z) report("point_z", z, e.z);
  endtask
endclass

// File: tb/tb_bezier_surface_point_eval.sv
`timescale 1ns / 100ps
// Testbench top for the Bezier surface point evaluator.
module tb_bezier_surface_point_eval;

  localparam int IDLE_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [3:0] cfg_wdata;

  bsp_in_if  in_ch ();
  bsp_out_if out_ch ();

  bezier_surface_point_eval u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_       (in_ch.sink),
    .out_      (out_ch.source)
  );

  bsp_scoreboard surf_sb = new();

  // Percent of cycles in which each side holds back.
  int send_gap_pct;
  int recv_stall_pct;
  int quiet_cycles;

  // Control points known to be written, so an evaluate word never touches an
  // unwritten control point.
  bit written [0:bsp_pkg::MAX_ROWS-1][0:bsp_pkg::MAX_COLS-1];
  int cur_rows;
  int cur_cols;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // The receiver stalls at random; every accepted word goes to the checker.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        surf_sb.check_result(out_ch.point_x, out_ch.point_y, out_ch.point_z);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Valid stays high after the accepting edge; the next word, a gap or drain() takes it down.
  task automatic send_word(logic req, logic [2:0] r, logic [2:0] c,
                           logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic [16:0] pu, logic [16:0] pv);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.row_index <= r;
    in_ch.col_index <= c;
    in_ch.ctrl_x    <= x;
    in_ch.ctrl_y    <= y;
    in_ch.ctrl_z    <= z;
    in_ch.param_u   <= pu;
    in_ch.param_v   <= pv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    surf_sb.note_input(req, r, c, x, y, z, pu, pv);
    if (req == bsp_pkg::REQ_WRITE) written[r][c] = 1'b1;
  endtask

  task automatic write_point(int r, int c, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    send_word(bsp_pkg::REQ_WRITE, 3'(r), 3'(c), x, y, z, 17'($urandom), 17'($urandom));
  endtask

  function automatic logic [16:0] rand_param();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return bsp_pkg::ONE_Q16;
      2: return 17'd65537 + 17'($urandom_range(65534));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  // Evaluate only once the active grid is fully written.
  task automatic evaluate(logic [16:0] pu, logic [16:0] pv);
    int nr, nc;
    nr = (cur_rows == 0) ? 1 : (cur_rows > bsp_pkg::MAX_ROWS) ? bsp_pkg::MAX_ROWS : cur_rows;
    nc = (cur_cols == 0) ? 1 : (cur_cols > bsp_pkg::MAX_COLS) ? bsp_pkg::MAX_COLS : cur_cols;
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++)
        if (!written[i][j]) write_point(i, j, rand_coord(), rand_coord(), rand_coord());
    send_word(bsp_pkg::REQ_EVAL, 3'($urandom), 3'($urandom), $urandom, $urandom, $urandom,
              pu, pv);
  endtask

  // Let all results drain, then wait out any trailing write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (surf_sb.pending_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Registers are written only when the block is idle.
  task automatic set_grid(int nr, int nc);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= bsp_pkg::CFG_ROWS;
    cfg_wdata <= 4'(nr);
    @(posedge clk);
    cfg_index <= bsp_pkg::CFG_COLS;
    cfg_wdata <= 4'(nc);
    @(posedge clk);
    cfg_we <= 1'b0;
    surf_sb.set_reg(bsp_pkg::CFG_ROWS, 4'(nr));
    surf_sb.set_reg(bsp_pkg::CFG_COLS, 4'(nc));
    cur_rows = nr;
    cur_cols = nc;
  endtask

  task automatic random_phase(int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 3) begin
        write_point($urandom_range(7), $urandom_range(7), rand_coord(), rand_coord(),
                    rand_coord());
      end else begin
        evaluate(rand_param(), rand_param());
      end
      n++;
      if ($urandom_range(199) == 0) set_grid($urandom_range(15), $urandom_range(15));
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = bsp_pkg::CFG_ROWS;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = bsp_pkg::REQ_WRITE;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.ctrl_x    = '0;
    in_ch.ctrl_y    = '0;
    in_ch.ctrl_z    = '0;
    in_ch.param_u   = '0;
    in_ch.param_v   = '0;
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    cur_rows        = 4;
    cur_cols        = 4;
    for (int i = 0; i < bsp_pkg::MAX_ROWS; i++)
      for (int j = 0; j < bsp_pkg::MAX_COLS; j++) written[i][j] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset-size grid at extreme coordinates and parameters.
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        write_point(i, j, (i + j) % 2 ? 32'sh7fffffff : 32'sh80000000,
                    32'sh80000000, 32'sh7fffffff);
    evaluate(17'd0, 17'd0);
    evaluate(bsp_pkg::ONE_Q16, bsp_pkg::ONE_Q16);
    evaluate(17'h1ffff, 17'd32768);
    evaluate(17'd32768, 17'h10001);
    // Single row and column pass the corner straight through; zero means one.
    set_grid(0, 0);
    evaluate(17'd12345, 17'd54321);
    set_grid(1, 8);
    write_point(7, 7, 32'sh12345678, -32'sd5, 32'sd1);
    evaluate(17'd1, 17'd65535);
    set_grid(15, 9);
    evaluate(17'd40000, 17'd20000);

    send_gap_pct = 26;
    recv_stall_pct = 47;
    random_phase(430);
    // Hold the sender until every expected point has arrived.
    drain();
    send_gap_pct = 47;
    recv_stall_pct = 26;
    set_grid(8, 1);
    random_phase(430);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_grid(2, 3);
    random_phase(430);

    drain();
    repeat (300) @(posedge clk);
    if (surf_sb.mismatch_count == 0 && surf_sb.pending_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
